FILE: rtl/lls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types and constants for the linked list segment splice block.
// ----------------------------------------------------------------------------
package lls_pkg;

   // width of every node field on the ports
   localparam int NW = 11;

   localparam int DEFAULT_MAX_NODES = 1024;
   localparam int RESET_LEN         = 1024;

   typedef enum logic [1:0] {
      OP_INIT = 2'd0,
      OP_MOVE = 2'd1,
      OP_WALK = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_MV_RD,
      ST_MV_W1,
      ST_MV_W2,
      ST_MV_W3,
      ST_WK_NXT,
      ST_WK_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;      // capture item fields
      logic rd_first;  // first link reads, addressed from the item ports or the walk cursor
      logic init_wr;   // one step of the rebuild sweep
      logic mv_cap;    // capture prev[first], next[last], read next[after]
      logic mv_w1;
      logic mv_w2;
      logic mv_w3;
      logic wk_step;   // check the next node and advance the cursor
      logic wk_chk;    // check for the tail sentinel
      logic emit;      // load the output register
   } lls_cmd_type;

   typedef struct packed {
      logic move_ok;
      logic init_end;
      logic walk_hit;
      logic out_free;
   } lls_stat_type;

endpackage

FILE: rtl/lls_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_ctrl
// Sequencer for init sweeps, segment moves and cursor walks.
// ----------------------------------------------------------------------------
module lls_ctrl import lls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic [1:0]   req_op,
   output logic         req_ready,
   input  lls_stat_type stat_i,
   output lls_cmd_type  cmd_o
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_op))
                  OP_INIT: state_in = ST_INIT;
                  OP_MOVE: state_in = stat_i.move_ok ? ST_MV_RD : ST_DONE;
                  OP_WALK: state_in = ST_WK_NXT;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_INIT: begin
            if (stat_i.init_end) state_in = ST_DONE;
         end
         ST_MV_RD:  state_in = ST_MV_W1;
         ST_MV_W1:  state_in = ST_MV_W2;
         ST_MV_W2:  state_in = ST_MV_W3;
         ST_MV_W3:  state_in = ST_DONE;
         ST_WK_NXT: state_in = stat_i.walk_hit ? ST_WK_CHK : ST_DONE;
         ST_WK_CHK: state_in = ST_DONE;
         ST_DONE: begin
            if (stat_i.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_o     = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               cmd_o.load = 1'b1;
               if ((op_type'(req_op) == OP_MOVE && stat_i.move_ok) ||
                   op_type'(req_op) == OP_WALK) begin
                  cmd_o.rd_first = 1'b1;
               end
            end
         end
         ST_INIT:   cmd_o.init_wr = 1'b1;
         ST_MV_RD:  cmd_o.mv_cap  = 1'b1;
         ST_MV_W1:  cmd_o.mv_w1   = 1'b1;
         ST_MV_W2:  cmd_o.mv_w2   = 1'b1;
         ST_MV_W3:  cmd_o.mv_w3   = 1'b1;
         ST_WK_NXT: cmd_o.wk_step = 1'b1;
         ST_WK_CHK: cmd_o.wk_chk  = 1'b1;
         ST_DONE:   cmd_o.emit    = stat_i.out_free;
         default:   cmd_o         = '0;
      endcase
   end

   a_init_goes_to_sweep: assert property (@(posedge clock) disable iff (reset)
      accept && op_type'(req_op) == OP_INIT |=> state_ff == ST_INIT)
      else $error("init item did not start the sweep");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd_o.emit |-> stat_i.out_free)
      else $error("result loaded while output register still full");

   a_done_releases_input: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && stat_i.out_free |=> req_ready)
      else $error("input not reopened after result was loaded");

endmodule

FILE: rtl/lls_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lls_dpath
// Link stores, move operand registers, walk cursor and output register.
// ----------------------------------------------------------------------------
module lls_dpath import lls_pkg::*; #(
   parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
   input  logic          clock,
   input  logic          reset,
   input  lls_cmd_type   cmd_i,
   output lls_stat_type  stat_o,
   input  logic [1:0]    req_op,
   input  logic [NW-1:0] req_seg_first,
   input  logic [NW-1:0] req_seg_last,
   input  logic [NW-1:0] req_after_node,
   input  logic          csr_wr_en,
   input  logic [NW-1:0] csr_wr_data,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output logic [NW-1:0] rsp_node,
   output logic          rsp_is_last
);

   localparam int DEPTH = MAX_NODES + 2;
   localparam int IW    = $clog2(DEPTH);
   localparam logic [NW-1:0] LEN_RST =
      NW'((RESET_LEN > MAX_NODES) ? MAX_NODES : RESET_LEN);

   logic [IW-1:0] next_mem [DEPTH];
   logic [IW-1:0] prev_mem [DEPTH];

   logic [NW-1:0] len_ff, len_in;
   logic [IW-1:0] tail_idx;
   logic [IW-1:0] a_ff, b_ff, k_ff;
   logic [IW-1:0] pa_ff, nb_ff, nk_ff, nk_in;
   logic [IW-1:0] cursor_ff;
   logic [IW-1:0] ic_ff;
   logic [IW-1:0] next_rd_ff, prev_rd_ff;
   logic [NW-1:0] res_node_ff;
   logic          res_last_ff;
   logic          rsp_valid_ff;
   logic [NW-1:0] rsp_node_ff;
   logic          rsp_last_ff;

   logic          nx_we, pv_we, nx_re, pv_re;
   logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, nx_ra, pv_ra;

   // length register, clipped to the supported range on write
   always_comb begin
      if (csr_wr_data == '0) begin
         len_in = NW'(1);
      end else if (32'(csr_wr_data) > 32'(MAX_NODES)) begin
         len_in = NW'(MAX_NODES);
      end else begin
         len_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RST;
      end else if (csr_wr_en) begin
         len_ff <= len_in;
      end
   end

   assign tail_idx = IW'(len_ff) + IW'(1);

   assign stat_o.move_ok  = (req_seg_first != '0) && (req_seg_first <= len_ff) &&
                            (req_seg_last != '0) && (req_seg_last <= len_ff) &&
                            (req_after_node <= len_ff);
   assign stat_o.init_end = (ic_ff == tail_idx);
   assign stat_o.walk_hit = (next_rd_ff != '0) && (32'(next_rd_ff) <= 32'(len_ff));
   assign stat_o.out_free = !rsp_valid_ff || rsp_ready;

   // the after node's next link may be rewritten by the first link write
   assign nk_in = (k_ff == pa_ff) ? nb_ff : next_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         a_ff <= IW'(req_seg_first);
         b_ff <= IW'(req_seg_last);
         k_ff <= IW'(req_after_node);
      end
      if (cmd_i.mv_cap) begin
         pa_ff <= prev_rd_ff;
         nb_ff <= next_rd_ff;
      end
      if (cmd_i.mv_w1) begin
         nk_ff <= nk_in;
      end
      if (cmd_i.load) begin
         ic_ff <= '0;
      end else if (cmd_i.init_wr) begin
         ic_ff <= ic_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (cmd_i.load) begin
         if (op_type'(req_op) == OP_INIT || op_type'(req_op) == OP_MOVE) begin
            cursor_ff <= '0;
         end
      end else if (cmd_i.wk_step) begin
         cursor_ff <= stat_o.walk_hit ? next_rd_ff : '0;
      end
   end

   // link store write ports
   always_comb begin
      nx_we = 1'b0;
      nx_wa = ic_ff;
      nx_wd = ic_ff + IW'(1);
      pv_we = 1'b0;
      pv_wa = ic_ff;
      pv_wd = ic_ff - IW'(1);
      if (cmd_i.init_wr) begin
         nx_we = (32'(ic_ff) <= 32'(len_ff));
         pv_we = (ic_ff != '0);
      end else if (cmd_i.mv_w1) begin
         nx_we = 1'b1;
         nx_wa = pa_ff;
         nx_wd = nb_ff;
         pv_we = 1'b1;
         pv_wa = nb_ff;
         pv_wd = pa_ff;
      end else if (cmd_i.mv_w2) begin
         nx_we = 1'b1;
         nx_wa = b_ff;
         nx_wd = nk_ff;
         pv_we = 1'b1;
         pv_wa = nk_ff;
         pv_wd = b_ff;
      end else if (cmd_i.mv_w3) begin
         nx_we = 1'b1;
         nx_wa = k_ff;
         nx_wd = a_ff;
         pv_we = 1'b1;
         pv_wa = a_ff;
         pv_wd = k_ff;
      end
   end

   // link store read ports
   always_comb begin
      nx_re = 1'b0;
      nx_ra = IW'(req_seg_last);
      pv_re = cmd_i.rd_first;
      pv_ra = IW'(req_seg_first);
      if (cmd_i.rd_first) begin
         nx_re = 1'b1;
         nx_ra = (op_type'(req_op) == OP_WALK) ? cursor_ff : IW'(req_seg_last);
      end else if (cmd_i.mv_cap) begin
         nx_re = 1'b1;
         nx_ra = k_ff;
      end else if (cmd_i.wk_step) begin
         nx_re = stat_o.walk_hit;
         nx_ra = next_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (nx_re) next_rd_ff <= next_mem[nx_ra];
   end

   always_ff @(posedge clock) begin
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (pv_re) prev_rd_ff <= prev_mem[pv_ra];
   end

   // staged result, then the output register
   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         res_node_ff <= '0;
         res_last_ff <= 1'b0;
      end else if (cmd_i.wk_chk) begin
         res_node_ff <= NW'(cursor_ff);
         res_last_ff <= (next_rd_ff == tail_idx);
      end
      if (cmd_i.emit) begin
         rsp_node_ff <= res_node_ff;
         rsp_last_ff <= res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_node    = rsp_node_ff;
   assign rsp_is_last = rsp_last_ff;

   a_cursor_on_real_node: assert property (@(posedge clock) disable iff (reset)
      cmd_i.wk_chk |-> cursor_ff != '0)
      else $error("tail check with cursor on the head sentinel");

endmodule

FILE: rtl/linked_list_segment_splice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_list_segment_splice
// Doubly linked list of nodes in two link memories with init, segment move
// and cursor walk items.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake
//  request  req_op, req_seg_first,     req_valid / req_ready
//           req_seg_last, req_after_node
//  response rsp_node, rsp_is_last      rsp_valid / rsp_ready
//  config   csr_wr_data                csr_wr_en, no wait
//
// an init item runs the rebuild sweep, which writes one entry of each link
// memory per cycle. a move is paced by the single read and write port of
// each link memory. a walk is paced by two dependent registered reads of
// the next links.
// the link memories hold no reset value; an init item must come first.
// a result waiting in the output register stalls the item after it at its
// last step only; the next item is taken while a result waits.
// ----------------------------------------------------------------------------
module linked_list_segment_splice import lls_pkg::*; #(
   parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_op,
   input  logic [NW-1:0] req_seg_first,
   input  logic [NW-1:0] req_seg_last,
   input  logic [NW-1:0] req_after_node,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [NW-1:0] rsp_node,
   output logic          rsp_is_last,
   input  logic          csr_wr_en,
   input  logic [NW-1:0] csr_wr_data
);

   lls_cmd_type  cmd;
   lls_stat_type stat;

   lls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .stat_i    (stat),
      .cmd_o     (cmd)
   );

   lls_dpath #(
      .MAX_NODES (MAX_NODES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd_i          (cmd),
      .stat_o         (stat),
      .req_op         (req_op),
      .req_seg_first  (req_seg_first),
      .req_seg_last   (req_seg_last),
      .req_after_node (req_after_node),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_node       (rsp_node),
      .rsp_is_last    (rsp_is_last)
   );

endmodule
